// ===== hw/rtl/lru_key_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// LRU key tracker assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_TRACKER_UNIT_ASSERT_SVH
`define LRU_KEY_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define LKT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check on every clock edge, reset included
`define LKT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LKT_ASSERT(name, prop, msg)
`define LKT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== hw/rtl/lkt_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key tracker package
// Request opcodes, default sizes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package lkt_pkg;

    // default sizes
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;

    // request opcodes
    typedef logic [2:0] req_op_t;
    localparam req_op_t OP_INSERT = 3'd0;
    localparam req_op_t OP_TOUCH  = 3'd1;
    localparam req_op_t OP_ERASE  = 3'd2;
    localparam req_op_t OP_CLEAR  = 3'd3;
    localparam req_op_t OP_LOOKUP = 3'd4;

    // update control for one cell of the recency chain
    typedef struct packed {
        logic upd;        // apply this cycle
        logic take_left;  // load key from the more recent neighbor
        logic take_right; // load key from the less recent neighbor
        logic valid_next; // slot holds a key after the update
    } cell_ctl_t;

endpackage

// ===== hw/rtl/lkt_cell.sv =====
// ----------------------------------------------------------------------------
// LRU key tracker cell
// One recency slot: holds a key and its valid bit, compares against the
// request key, and shifts toward either neighbor on update.
// ----------------------------------------------------------------------------
module lkt_cell #(
    parameter int KEY_BITS = lkt_pkg::KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmp_en,
    input  logic [KEY_BITS-1:0] cmp_key,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [KEY_BITS-1:0] right_key,
    input  lkt_pkg::cell_ctl_t  ctl,
    output logic [KEY_BITS-1:0] key_out,
    output logic                valid_out,
    output logic                match_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                valid_reg;
    logic                match_reg;

    // key shift select
    always_comb begin
        key_next = key_reg;
        if (ctl.take_left) begin
            key_next = left_key;
        end else if (ctl.take_right) begin
            key_next = right_key;
        end
    end

    // key storage, no reset: only valid slots are ever read
    always_ff @(posedge aclk) begin
        if (ctl.upd) begin
            key_reg <= key_next;
        end
    end

    // valid bit and registered compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctl.upd) begin
                valid_reg <= ctl.valid_next;
            end
            if (cmp_en) begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign match_out = match_reg;

endmodule

// ===== hw/rtl/lru_key_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// LRU key tracker
// Fully associative recency tracker built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Timing: the result is registered in the update state that follows an accepted
//   request, later while the previous result still waits on m_ready.
// Requests: each one runs a compare in all cells, then a shift along the cell
//   chain; a new request is taken only once that shift is applied.
// Reset: synchronous; clears slot valid bits, occupancy and output valid.
//   Slot keys are not cleared and no clearing pass is needed.
`include "lru_key_tracker_unit_assert.svh"

module lru_key_tracker_unit #(
    parameter int CAPACITY = lkt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = lkt_pkg::KEY_BITS_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_req_type,
    input  logic [31:0]         s_req_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_key_hit,
    output logic                m_evict_valid,
    output logic [31:0]         m_evict_key,
    output logic [CNT_W-1:0]    m_occupancy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                state_reg;
    logic                state_next;
    lkt_pkg::req_op_t    op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] in_key;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                m_valid_reg;
    logic                m_key_hit_reg;
    logic                m_evict_valid_reg;
    logic [31:0]         m_evict_key_reg;
    logic [CNT_W-1:0]    m_occupancy_reg;

    logic                accept;
    logic                out_free;
    logic                apply;

    logic [KEY_BITS-1:0] cell_key  [CAPACITY];
    logic [KEY_BITS-1:0] cell_left [CAPACITY];
    logic [KEY_BITS-1:0] cell_right[CAPACITY];
    lkt_pkg::cell_ctl_t  cell_ctl  [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY:0]   ext_valid;

    logic [CAPACITY-1:0] at_or_after;
    logic [CAPACITY-1:0] at_or_before;
    logic [CAPACITY-1:0] take_left;
    logic [CAPACITY-1:0] take_right;
    logic                hit;
    logic                hit_rep;
    logic                full;
    logic                evict_v;

    // handshake
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign apply    = (state_reg == ST_UPD) && out_free;
    assign in_key   = KEY_BITS'(s_req_key);

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_left[g] = key_reg;
        end else begin : g_body
            assign cell_left[g] = cell_key[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign cell_right[g] = cell_key[g];
        end else begin : g_inner
            assign cell_right[g] = cell_key[g+1];
        end

        lkt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmp_en    (accept),
            .cmp_key   (in_key),
            .left_key  (cell_left[g]),
            .right_key (cell_right[g]),
            .ctl       (cell_ctl[g]),
            .key_out   (cell_key[g]),
            .valid_out (valid_vec[g]),
            .match_out (match_vec[g])
        );
    end

    // match position masks over the registered compare results
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            at_or_after[i]  = |(match_vec >> i);
            at_or_before[i] = |(match_vec << (CAPACITY - 1 - i));
        end
    end

    assign hit       = |match_vec;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign ext_valid = {valid_vec, 1'b1};

    // per-opcode shift pattern and occupancy
    always_comb begin
        take_left  = '0;
        take_right = '0;
        count_next = count_reg;
        evict_v    = 1'b0;
        hit_rep    = 1'b0;
        unique case (op_reg)
            lkt_pkg::OP_INSERT: begin
                hit_rep = hit;
                if (hit) begin
                    take_left = at_or_after;
                end else if (full) begin
                    take_left = '1;
                    evict_v   = 1'b1;
                end else begin
                    take_left  = ext_valid[CAPACITY-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            lkt_pkg::OP_TOUCH: begin
                hit_rep = hit;
                if (hit) begin
                    take_left = at_or_after;
                end
            end
            lkt_pkg::OP_ERASE: begin
                hit_rep = hit;
                if (hit) begin
                    take_right = at_or_before;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            lkt_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            lkt_pkg::OP_LOOKUP: begin
                hit_rep = hit;
            end
            default: begin
            end
        endcase
    end

    // control bundle for each cell
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].upd        = apply;
            cell_ctl[i].take_left  = take_left[i];
            cell_ctl[i].take_right = take_right[i];
            cell_ctl[i].valid_next = (CNT_W'(i) < count_next);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_req_type;
            key_reg <= in_key;
        end
        if (apply) begin
            m_key_hit_reg     <= hit_rep;
            m_evict_valid_reg <= evict_v;
            m_evict_key_reg   <= evict_v ? 32'(cell_key[CAPACITY-1]) : '0;
            m_occupancy_reg   <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_key_hit     = m_key_hit_reg;
    assign m_evict_valid = m_evict_valid_reg;
    assign m_evict_key   = m_evict_key_reg;
    assign m_occupancy   = m_occupancy_reg;

    // checks
    `LKT_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "occupancy above capacity")
    `LKT_ASSERT(a_single_match, state_reg == ST_UPD |-> $onehot0(match_vec), "duplicate key held")
    `LKT_ASSERT(a_valid_count, $countones(valid_vec) == 32'(count_reg), "valid bits disagree with count")
    `LKT_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> s_ready && !m_valid, "not idle after reset")

endmodule
